// ----- hw/rtl/stack_machine_alu_defines.svh -----
// Assertion macros for the stack machine ALU.
`ifndef STACK_MACHINE_ALU_DEFINES_SVH
`define STACK_MACHINE_ALU_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SMA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SMA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/sma_pkg.sv -----
// Shared types and constants for the stack machine ALU.
package sma_pkg;

  localparam int DATA_W      = 32;
  localparam int STACK_DEPTH = 64;
  localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int STEP_W      = $clog2(DATA_W);

  typedef enum logic [2:0] {
    OP_NOP  = 3'd0,
    OP_PUSH = 3'd1,
    OP_SWAP = 3'd2,
    OP_ADD  = 3'd3,
    OP_SUB  = 3'd4,
    OP_DIV  = 3'd5
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_UNDER   = 2'd1,
    ST_DIVZERO = 2'd2,
    ST_OVER    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_DIV
  } alu_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_READ,
    S_EXEC,
    S_FINISH
  } ctrl_state_t;

  typedef enum logic [2:0] {
    A_IDLE,
    A_ARITH,
    A_NEG_N,
    A_NEG_D,
    A_STEP,
    A_FIX
  } alu_state_t;

  typedef struct packed {
    logic [2:0]               opcode;
    logic signed [DATA_W-1:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] top_value;
    logic [6:0]               stack_depth;
  } out_item_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef struct packed {
    logic done;
  } alu_rsp_t;

endpackage

// ----- hw/rtl/sma_alu.sv -----
// Shared iterative ALU: one adder serves add, sub and a restoring signed divide.
module sma_alu import sma_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  alu_req_t          req,
  input  logic [DATA_W-1:0] a,
  input  logic [DATA_W-1:0] b,
  output alu_rsp_t          rsp,
  output logic [DATA_W-1:0] result
);

  alu_state_t          state, state_next;
  alu_op_t             op;
  logic [DATA_W-1:0]   rem;
  logic [DATA_W-1:0]   quo;
  logic [DATA_W-1:0]   dvs;
  logic                a_neg;
  logic                b_neg;
  logic                q_neg;
  logic [STEP_W-1:0]   step;
  logic                done;

  logic [DATA_W-1:0]   add_x;
  logic [DATA_W-1:0]   add_y;
  logic                add_sub;
  logic [DATA_W:0]     sum;
  logic [DATA_W-1:0]   trial;

  assign trial = {rem[DATA_W-2:0], quo[DATA_W-1]};
  assign sum   = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)}
               + {{DATA_W{1'b0}}, add_sub};

  always_comb begin
    state_next = state;
    add_x      = '0;
    add_y      = quo;
    add_sub    = 1'b0;
    case (state)
      A_IDLE: begin
        if (req.start) begin
          state_next = (req.op == ALU_DIV) ? A_NEG_N : A_ARITH;
        end
      end
      A_ARITH: begin
        add_x      = quo;
        add_y      = dvs;
        add_sub    = (op == ALU_SUB);
        state_next = A_IDLE;
      end
      A_NEG_N: begin
        add_y      = quo;
        add_sub    = 1'b1;
        state_next = A_NEG_D;
      end
      A_NEG_D: begin
        add_y      = dvs;
        add_sub    = 1'b1;
        state_next = A_STEP;
      end
      A_STEP: begin
        add_x   = trial;
        add_y   = dvs;
        add_sub = 1'b1;
        if (step == STEP_W'(DATA_W - 1)) begin
          state_next = A_FIX;
        end
      end
      A_FIX: begin
        // Pass the quotient through, or negate it when the signs differ.
        add_y      = quo;
        add_sub    = q_neg;
        state_next = A_IDLE;
      end
      default: begin
        state_next = A_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= A_IDLE;
      done  <= 1'b0;
      step  <= '0;
    end else begin
      state <= state_next;
      done  <= (state == A_ARITH) || (state == A_FIX);
      if (state == A_NEG_D) begin
        step <= '0;
      end else if (state == A_STEP) begin
        step <= step + STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      A_IDLE: begin
        if (req.start) begin
          op    <= req.op;
          quo   <= a;
          dvs   <= b;
          rem   <= '0;
          a_neg <= a[DATA_W-1];
          b_neg <= b[DATA_W-1];
          q_neg <= a[DATA_W-1] ^ b[DATA_W-1];
        end
      end
      A_ARITH: begin
        result <= sum[DATA_W-1:0];
      end
      A_NEG_N: begin
        if (a_neg) begin
          quo <= sum[DATA_W-1:0];
        end
      end
      A_NEG_D: begin
        if (b_neg) begin
          dvs <= sum[DATA_W-1:0];
        end
      end
      A_STEP: begin
        // Carry out means the trial remainder covers the divisor: keep the difference.
        if (sum[DATA_W]) begin
          rem <= sum[DATA_W-1:0];
          quo <= {quo[DATA_W-2:0], 1'b1};
        end else begin
          rem <= trial;
          quo <= {quo[DATA_W-2:0], 1'b0};
        end
      end
      A_FIX: begin
        result <= sum[DATA_W-1:0];
      end
      default: begin
      end
    endcase
  end

  assign rsp.done = done;

endmodule

// ----- hw/rtl/stack_machine_alu.sv -----
// Top level of the stack machine ALU: sequencer, operand stack and output register.
//
// Operand-stack execution unit, one instruction per input transaction and one
// result per instruction. The block works on one instruction at a time and
// holds in_stall high until it finishes; a finished result sits in the output
// register, so the next instruction is taken while that result waits. Nop, push
// and any instruction that ends in underflow, overflow or divide by zero go from
// dispatch to finish; swap adds a read step, and add, sub and div add read and
// execute steps. Divide uses the shared ALU's restoring loop, one quotient bit
// per cycle through its single adder, plus operand and sign fix-up steps. The
// top entry lives in a register; the rest of the stack lives in a 64-entry
// memory with one write port and one registered read port.
`include "stack_machine_alu_defines.svh"

module stack_machine_alu import sma_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  ctrl_state_t       state, state_next;
  logic [2:0]        op_q;
  logic [DATA_W-1:0] val_q;
  logic [DATA_W-1:0] top, top_next;
  logic [CNT_W-1:0]  cnt, cnt_next;
  logic [1:0]        status_q, status_next;

  logic [DATA_W-1:0] mem [STACK_DEPTH];
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic [IDX_W-1:0]  mem_raddr;
  logic [DATA_W-1:0] rd_data;

  alu_req_t          alu_req;
  alu_rsp_t          alu_rsp;
  logic [DATA_W-1:0] alu_result;
  logic              out_load;

  assign in_stall  = (state != S_IDLE);
  assign mem_raddr = IDX_W'(cnt - CNT_W'(2));

  sma_alu u_alu (
    .clk    (clk),
    .rst    (rst),
    .req    (alu_req),
    .a      (rd_data),
    .b      (top),
    .rsp    (alu_rsp),
    .result (alu_result)
  );

  always_comb begin
    state_next  = state;
    top_next    = top;
    cnt_next    = cnt;
    status_next = status_q;
    mem_we      = 1'b0;
    mem_waddr   = IDX_W'(cnt - CNT_W'(1));
    mem_wdata   = top;
    alu_req     = '{start: 1'b0, op: ALU_ADD};
    out_load    = 1'b0;
    case (op_q)
      OP_SUB:  alu_req.op = ALU_SUB;
      OP_DIV:  alu_req.op = ALU_DIV;
      default: alu_req.op = ALU_ADD;
    endcase
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        status_next = ST_OK;
        state_next  = S_FINISH;
        case (op_q)
          OP_PUSH: begin
            if (cnt == CNT_W'(STACK_DEPTH)) begin
              status_next = ST_OVER;
            end else begin
              // Spill the old top into the memory, then take the new value.
              mem_we   = (cnt != '0);
              top_next = val_q;
              cnt_next = cnt + CNT_W'(1);
            end
          end
          OP_SWAP, OP_ADD, OP_SUB, OP_DIV: begin
            if (cnt < CNT_W'(2)) begin
              status_next = ST_UNDER;
            end else if (op_q == OP_DIV && top == '0) begin
              status_next = ST_DIVZERO;
            end else begin
              state_next = S_READ;
            end
          end
          default: begin
          end
        endcase
      end
      S_READ: begin
        if (op_q == OP_SWAP) begin
          mem_we     = 1'b1;
          mem_waddr  = mem_raddr;
          top_next   = rd_data;
          state_next = S_FINISH;
        end else begin
          alu_req.start = 1'b1;
          state_next    = S_EXEC;
        end
      end
      S_EXEC: begin
        if (alu_rsp.done) begin
          top_next   = alu_result;
          cnt_next   = cnt - CNT_W'(1);
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        // Hold until the output register is free.
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    top      <= top_next;
    status_q <= status_next;
    if (state == S_IDLE && in_valid) begin
      op_q  <= in_item.opcode;
      val_q <= in_item.push_value;
    end
    if (out_load) begin
      out_item.status      <= status_q;
      out_item.top_value   <= (cnt != '0) ? top : '0;
      out_item.stack_depth <= 7'(cnt);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[mem_raddr];
  end

  `SMA_ASSERT_NOW(a_depth_bound, 1'b1, cnt <= CNT_W'(STACK_DEPTH),
    "stack depth beyond capacity")
  `SMA_ASSERT_NOW(a_over_full, out_valid && out_item.status == ST_OVER,
    out_item.stack_depth == 7'(STACK_DEPTH), "overflow reported on a stack that is not full")
  `SMA_ASSERT_NOW(a_under_short, out_valid && out_item.status == ST_UNDER,
    out_item.stack_depth < 7'd2, "underflow reported with two or more entries")
  `SMA_ASSERT_NOW(a_alu_done_exec, alu_rsp.done, state == S_EXEC,
    "ALU finished outside the execute step")
  `SMA_ASSERT_NEXT(a_load_holds, out_load, out_valid && state == S_IDLE,
    "result load did not present a transaction")

endmodule

// ----- sim/stack_result_checker.sv -----
// Checker for the stack machine ALU: tracks the operand stack and compares every result.
module stack_result_checker import sma_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_item,
  output int        mismatches,
  output int        outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [DATA_W-1:0] model_stack [STACK_DEPTH];
  int unsigned       model_count;
  out_item_t         expected_results [$];
  int                fail_count = 0;

  assign mismatches = fail_count;

  // Truncate toward zero; the most negative value over minus one wraps back to itself.
  function automatic logic [DATA_W-1:0] signed_quotient(logic [DATA_W-1:0] num,
                                                        logic [DATA_W-1:0] den);
    logic [DATA_W-1:0] mag_n;
    logic [DATA_W-1:0] mag_d;
    logic [DATA_W-1:0] q;
    mag_n = num[DATA_W-1] ? -num : num;
    mag_d = den[DATA_W-1] ? -den : den;
    q = mag_n / mag_d;
    return (num[DATA_W-1] ^ den[DATA_W-1]) ? -q : q;
  endfunction

  function automatic out_item_t execute_instruction(in_item_t instr);
    out_item_t         res;
    status_t           st;
    logic [DATA_W-1:0] top;
    logic [DATA_W-1:0] second;
    st = ST_OK;
    case (instr.opcode)
      OP_PUSH: begin
        if (model_count >= STACK_DEPTH) begin
          st = ST_OVER;
        end else begin
          model_stack[model_count] = instr.push_value;
          model_count++;
        end
      end
      OP_SWAP, OP_ADD, OP_SUB, OP_DIV: begin
        if (model_count < 2) begin
          st = ST_UNDER;
        end else begin
          top    = model_stack[model_count-1];
          second = model_stack[model_count-2];
          if (instr.opcode == OP_SWAP) begin
            model_stack[model_count-1] = second;
            model_stack[model_count-2] = top;
          end else if (instr.opcode == OP_DIV && top == '0) begin
            st = ST_DIVZERO;
          end else begin
            case (instr.opcode)
              OP_ADD:  second = second + top;
              OP_SUB:  second = second - top;
              default: second = signed_quotient(second, top);
            endcase
            model_stack[model_count-2] = second;
            model_count--;
          end
        end
      end
      default: ;
    endcase
    res.status      = st;
    res.top_value   = (model_count > 0) ? model_stack[model_count-1] : '0;
    res.stack_depth = 7'(model_count);
    return res;
  endfunction

  always @(posedge clk) begin : watch
    out_item_t want;
    if (rst) begin
      model_count = 0;
      expected_results.delete();
      outstanding <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(execute_instruction(in_item));
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with none expected: status %0d top %h depth %0d",
                   $time, out_item.status, out_item.top_value, out_item.stack_depth);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_item.status !== want.status) begin
            $display("%0t: status expected %0d, got %0d",
                     $time, want.status, out_item.status);
            fail_count++;
          end
          if (out_item.top_value !== want.top_value) begin
            $display("%0t: top_value expected %h, got %h",
                     $time, want.top_value, out_item.top_value);
            fail_count++;
          end
          if (out_item.stack_depth !== want.stack_depth) begin
            $display("%0t: stack_depth expected %0d, got %0d",
                     $time, want.stack_depth, out_item.stack_depth);
            fail_count++;
          end
        end
      end
      outstanding <= expected_results.size();
    end
  end

endmodule

// ----- sim/tb.sv -----
// Testbench top for the stack machine ALU: instruction stimulus, output stalls and verdict.
module tb import sma_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int                RANDOM_ITEMS = 1500;
  localparam int                RUN_LIMIT    = 600_000;
  localparam int                SETTLE       = 60;
  localparam logic [2:0]        OP_SPARE_A   = 3'd6;
  localparam logic [2:0]        OP_SPARE_B   = 3'd7;
  localparam logic [DATA_W-1:0] MOST_POS     = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] MOST_NEG     = 32'h8000_0000;

  typedef enum {STALL_NONE, STALL_RANDOM, STALL_HOLD} stall_mode_t;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;
  int        mismatches;
  int        outstanding;
  int        cycle_count = 0;

  stall_mode_t stall_mode = STALL_NONE;
  int          stall_left = 0;

  stack_machine_alu dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  stack_result_checker result_check (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver: alternate free-flowing, random and solid stall stretches.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      case ($urandom_range(3))
        0:       stall_mode = STALL_RANDOM;
        1:       stall_mode = STALL_HOLD;
        default: stall_mode = STALL_NONE;
      endcase
      stall_left = (stall_mode == STALL_HOLD) ? $urandom_range(1, 12) : $urandom_range(4, 40);
    end
    stall_left--;
    case (stall_mode)
      STALL_RANDOM: out_stall <= 1'($urandom_range(1));
      STALL_HOLD:   out_stall <= 1'b1;
      default:      out_stall <= 1'b0;
    endcase
  end

  function automatic in_item_t instr(logic [2:0] op, logic [DATA_W-1:0] value);
    in_item_t it;
    it.opcode     = op;
    it.push_value = value;
    return it;
  endfunction

  // Lean on zero and the extremes so divide by zero and wrapping come up often.
  function automatic logic [DATA_W-1:0] random_value();
    case ($urandom_range(15))
      0, 1:    return '0;
      2:       return MOST_NEG;
      3:       return MOST_POS;
      4:       return '1;
      5:       return 1;
      6, 7:    return $urandom_range(20) - 10;
      default: return $urandom;
    endcase
  endfunction

  function automatic in_item_t random_instruction(int push_pct);
    logic [2:0] op;
    if ($urandom_range(99) < push_pct) begin
      op = OP_PUSH;
    end else begin
      case ($urandom_range(19))
        0:              op = OP_NOP;
        1, 2, 3:        op = OP_SWAP;
        4, 5, 6, 7, 8:  op = OP_ADD;
        9, 10, 11, 12:  op = OP_SUB;
        18:             op = OP_SPARE_A;
        19:             op = OP_SPARE_B;
        default:        op = OP_DIV;
      endcase
    end
    return instr(op, random_value());
  endfunction

  // Hold the transaction until it is taken.
  task automatic send(in_item_t it);
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic pause(int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  initial begin
    int  sent;
    int  seg_len;
    int  burst;
    int  gap;
    int  push_pct;
    bit  fill;
    bit  no_gaps;
    bit  first_seg;
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_item   = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    send(instr(OP_NOP, $urandom));
    send(instr(OP_SWAP, $urandom));       // underflow on empty stack
    send(instr(OP_DIV, $urandom));
    send(instr(OP_PUSH, MOST_POS));
    send(instr(OP_ADD, $urandom));        // underflow with one entry
    send(instr(OP_SUB, $urandom));
    send(instr(OP_PUSH, 1));
    send(instr(OP_ADD, $urandom));        // wraps to most negative
    send(instr(OP_PUSH, '1));
    send(instr(OP_DIV, $urandom));        // most negative over minus one
    send(instr(OP_PUSH, '0));
    send(instr(OP_DIV, $urandom));        // divide by zero, stack kept
    send(instr(OP_SWAP, $urandom));
    send(instr(OP_SUB, $urandom));        // zero minus most negative wraps
    send(instr(OP_PUSH, -7));
    send(instr(OP_PUSH, 2));
    send(instr(OP_DIV, $urandom));        // truncates toward zero
    send(instr(OP_PUSH, MOST_NEG));
    send(instr(OP_SUB, $urandom));
    send(instr(OP_SPARE_A, $urandom));
    send(instr(OP_SPARE_B, $urandom));
    send(instr(OP_PUSH, 5));
    send(instr(OP_PUSH, -2));
    send(instr(OP_DIV, $urandom));
    send(instr(OP_ADD, $urandom));

    // Alternate filling and draining so both overflow and underflow are reached.
    sent      = 0;
    fill      = 1'b1;
    first_seg = 1'b1;
    while (sent < RANDOM_ITEMS) begin
      seg_len  = $urandom_range(40, 150);
      push_pct = fill ? 85 : 15;
      if ($urandom_range(3) == 0) push_pct = 50;
      fill    = !fill;
      no_gaps = ($urandom_range(3) == 0);
      while (seg_len > 0) begin
        burst = $urandom_range(1, 24);
        if (burst > seg_len) burst = seg_len;
        repeat (burst) send(random_instruction(push_pct));
        seg_len -= burst;
        sent    += burst;
        gap = no_gaps ? 0 : $urandom_range(0, 12);
        if (gap > 0) pause(gap);
      end
      if (first_seg || $urandom_range(3) == 0) wait_for_results();
      first_seg = 1'b0;
    end

    wait_for_results();
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/sma_pkg.sv
hw/rtl/sma_alu.sv
hw/rtl/stack_machine_alu.sv
sim/stack_result_checker.sv
sim/tb.sv
